>>> rtl/acc_gap_speed_controller_top_assert.svh
// assertion macros for the cruise gap/speed controller top level
`ifndef ACC_GAP_SPEED_CONTROLLER_TOP_ASSERT_SVH
`define ACC_GAP_SPEED_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ACC_GSC_AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acc_gsc assertion failed");

// next-cycle implication, checked at every rising edge out of reset
`define ACC_GSC_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acc_gsc assertion failed");

`endif

>>> rtl/acc_gsc_pkg.sv
// shared types and constants of the cruise gap/speed controller
`default_nettype none

package acc_gsc_pkg;

  // fixed vehicle constants, 1/256 units
  localparam int MIN_GAP         = 640;
  localparam int STEP_LENGTH     = 256;
  localparam int UPPER_GAP_LIMIT = 30720;
  localparam int LOWER_GAP_LIMIT = 25600;

  // gap mode tolerances: 0.2 m and 0.1 m/s
  localparam int SPACE_TOL = 51;
  localparam int SPEED_TOL = 25;

  // configuration register indexes
  localparam logic [2:0] CFG_SPEED_GAIN         = 3'd0;
  localparam logic [2:0] CFG_GAP_GAIN_SPEED     = 3'd1;
  localparam logic [2:0] CFG_GAP_GAIN_SPACE     = 3'd2;
  localparam logic [2:0] CFG_CLOSING_GAIN_SPEED = 3'd3;
  localparam logic [2:0] CFG_CLOSING_GAIN_SPACE = 3'd4;
  localparam logic [2:0] CFG_AVOID_GAIN_SPEED   = 3'd5;
  localparam logic [2:0] CFG_AVOID_GAIN_SPACE   = 3'd6;
  localparam logic [2:0] CFG_HEADWAY_TIME       = 3'd7;

  // control law codes
  typedef enum logic [1:0] {
    LAW_SPEED = 2'd0,
    LAW_GAP   = 2'd1,
    LAW_AVOID = 2'd2,
    LAW_CLOSE = 2'd3
  } law_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DES,
    ST_ERR,
    ST_CLS,
    ST_MUL,
    ST_ACC,
    ST_SPD,
    ST_DONE
  } state_t;

  // configuration register set
  typedef struct packed {
    logic signed [15:0] speed_gain;
    logic signed [15:0] gap_gain_speed;
    logic signed [15:0] gap_gain_space;
    logic signed [15:0] closing_gain_speed;
    logic signed [15:0] closing_gain_space;
    logic signed [15:0] avoid_gain_speed;
    logic signed [15:0] avoid_gain_space;
    logic        [11:0] headway_time;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic des;
    logic err;
    logic cls;
    logic mul;
    logic acc;
    logic spd;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/acc_gsc_ctrl.sv
// sequencer that steps one word through the datapath
`default_nettype none

module acc_gsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire acc_gsc_pkg::sts_t sts,
  output acc_gsc_pkg::cmd_t      cmd,
  output logic                   busy
);

  acc_gsc_pkg::state_t state_r;
  acc_gsc_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acc_gsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acc_gsc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = acc_gsc_pkg::ST_DES;
      end
      acc_gsc_pkg::ST_DES: state_nxt = acc_gsc_pkg::ST_ERR;
      acc_gsc_pkg::ST_ERR: state_nxt = acc_gsc_pkg::ST_CLS;
      acc_gsc_pkg::ST_CLS: state_nxt = acc_gsc_pkg::ST_MUL;
      acc_gsc_pkg::ST_MUL: state_nxt = acc_gsc_pkg::ST_ACC;
      acc_gsc_pkg::ST_ACC: state_nxt = acc_gsc_pkg::ST_SPD;
      acc_gsc_pkg::ST_SPD: state_nxt = acc_gsc_pkg::ST_DONE;
      acc_gsc_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = acc_gsc_pkg::ST_IDLE;
      end
      default: state_nxt = acc_gsc_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      acc_gsc_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = in_valid;
      end
      acc_gsc_pkg::ST_DES:  cmd.des = 1'b1;
      acc_gsc_pkg::ST_ERR:  cmd.err = 1'b1;
      acc_gsc_pkg::ST_CLS:  cmd.cls = 1'b1;
      acc_gsc_pkg::ST_MUL:  cmd.mul = 1'b1;
      acc_gsc_pkg::ST_ACC:  cmd.acc = 1'b1;
      acc_gsc_pkg::ST_SPD:  cmd.spd = 1'b1;
      acc_gsc_pkg::ST_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/acc_gsc_dp.sv
// datapath: law selection, spacing error, gain products, saturation
`default_nettype none

module acc_gsc_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire acc_gsc_pkg::cfg_t   cfg,
  input  wire acc_gsc_pkg::cmd_t   cmd,
  output acc_gsc_pkg::sts_t        sts,
  input  wire logic signed [23:0]  in_gap_distance,
  input  wire logic        [15:0]  in_own_speed,
  input  wire logic        [15:0]  in_leader_speed,
  input  wire logic        [15:0]  in_target_speed,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic signed      [15:0]  out_accel_value,
  output logic             [15:0]  out_next_speed,
  output logic             [1:0]   out_law_used
);

  localparam logic signed [24:0] UPPER_LIM = 25'(acc_gsc_pkg::UPPER_GAP_LIMIT);
  localparam logic signed [24:0] LOWER_LIM = 25'(acc_gsc_pkg::LOWER_GAP_LIMIT);
  localparam logic signed [25:0] MIN_GAP_E = 26'(acc_gsc_pkg::MIN_GAP);
  localparam logic signed [25:0] E_TOL     = 26'(acc_gsc_pkg::SPACE_TOL);
  localparam logic signed [16:0] D_TOL     = 17'(acc_gsc_pkg::SPEED_TOL);
  localparam logic signed [28:0] STEP_S    = 29'(acc_gsc_pkg::STEP_LENGTH);
  localparam logic signed [29:0] ACC_MAX   = 30'sd32767;
  localparam logic signed [29:0] ACC_MIN   = -30'sd32768;
  localparam logic signed [22:0] NV_MAX    = 23'sd65535;

  // captured word and mode bit
  logic signed [23:0] gap_r;
  logic        [15:0] v_r;
  logic        [15:0] vl_r;
  logic        [15:0] vd_r;
  logic               mode_r;

  // intermediate registers
  logic        [19:0] des_r;
  logic signed [25:0] e_r;
  logic signed [16:0] d_r;
  logic signed [16:0] sp_r;
  acc_gsc_pkg::law_t  law_r;
  logic signed [15:0] ga_r;
  logic signed [15:0] gb_r;
  logic signed [16:0] opa_r;
  logic signed [32:0] pa_r;
  logic signed [41:0] pb_r;
  logic signed [15:0] acc_r;
  logic        [15:0] nv_r;

  // output register
  logic               out_valid_r;
  logic signed [15:0] out_accel_r;
  logic        [15:0] out_speed_r;
  logic        [1:0]  out_law_r;

  // combinational helpers
  logic        [27:0] des_prod;
  logic signed [24:0] gap_in_ext;
  logic               in_tol;
  logic signed [43:0] round_sum;
  logic signed [29:0] acc_q;
  logic signed [28:0] step_prod;
  logic signed [29:0] step_rnd;
  logic signed [21:0] step_q;
  logic signed [22:0] nv_sum;

  assign gap_in_ext = 25'(in_gap_distance);
  assign des_prod   = 28'(cfg.headway_time) * 28'(v_r) + 28'd128;
  assign in_tol     = (e_r >= -E_TOL) && (e_r <= E_TOL) &&
                      (d_r >= -D_TOL) && (d_r <= D_TOL);
  assign round_sum  = 44'(pa_r) + 44'(pb_r) + 44'sd8192;
  assign acc_q      = 30'(round_sum >>> 14);
  assign step_prod  = 29'(acc_r) * STEP_S;
  assign step_rnd   = 30'(step_prod) + 30'sd128;
  assign step_q     = 22'(step_rnd >>> 8);
  assign nv_sum     = $signed({7'b0, v_r}) + 23'(step_q);

  // mode bit follows the gap limits on every word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cmd.load) begin
      if (gap_in_ext > UPPER_LIM) begin
        mode_r <= 1'b0;
      end else if (gap_in_ext < LOWER_LIM) begin
        mode_r <= 1'b1;
      end
    end
  end

  // capture word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gap_r <= in_gap_distance;
      v_r   <= in_own_speed;
      vl_r  <= in_leader_speed;
      vd_r  <= in_target_speed;
    end
  end

  // desired spacing from headway
  always_ff @(posedge clk) begin
    if (cmd.des) begin
      des_r <= des_prod[27:8];
    end
  end

  // spacing error and speed differences
  always_ff @(posedge clk) begin
    if (cmd.err) begin
      e_r  <= 26'(gap_r) - MIN_GAP_E - $signed({6'b0, des_r});
      d_r  <= $signed({1'b0, vl_r}) - $signed({1'b0, v_r});
      sp_r <= $signed({1'b0, v_r}) - $signed({1'b0, vd_r});
    end
  end

  // pick law, gains and operand
  always_ff @(posedge clk) begin
    if (cmd.cls) begin
      if (!mode_r) begin
        law_r <= acc_gsc_pkg::LAW_SPEED;
        ga_r  <= cfg.speed_gain;
        gb_r  <= '0;
        opa_r <= sp_r;
      end else if (in_tol) begin
        law_r <= acc_gsc_pkg::LAW_GAP;
        ga_r  <= cfg.gap_gain_speed;
        gb_r  <= cfg.gap_gain_space;
        opa_r <= d_r;
      end else if (e_r < 0) begin
        law_r <= acc_gsc_pkg::LAW_AVOID;
        ga_r  <= cfg.avoid_gain_speed;
        gb_r  <= cfg.avoid_gain_space;
        opa_r <= d_r;
      end else begin
        law_r <= acc_gsc_pkg::LAW_CLOSE;
        ga_r  <= cfg.closing_gain_speed;
        gb_r  <= cfg.closing_gain_space;
        opa_r <= d_r;
      end
    end
  end

  // gain products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pa_r <= 33'(ga_r) * 33'(opa_r);
      pb_r <= 42'(gb_r) * 42'(e_r);
    end
  end

  // q14 rounding and acceleration saturation
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      if (acc_q > ACC_MAX) begin
        acc_r <= 16'sh7fff;
      end else if (acc_q < ACC_MIN) begin
        acc_r <= -16'sh8000;
      end else begin
        acc_r <= acc_q[15:0];
      end
    end
  end

  // new speed clamped to range
  always_ff @(posedge clk) begin
    if (cmd.spd) begin
      if (nv_sum < 0) begin
        nv_r <= '0;
      end else if (nv_sum > NV_MAX) begin
        nv_r <= 16'hffff;
      end else begin
        nv_r <= nv_sum[15:0];
      end
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accel_r <= acc_r;
      out_speed_r <= nv_r;
      out_law_r   <= law_r;
    end
  end

  assign sts.out_free    = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_accel_value = out_accel_r;
  assign out_next_speed  = out_speed_r;
  assign out_law_used    = out_law_r;

endmodule

`default_nettype wire

>>> rtl/acc_gap_speed_controller_top.sv
// top level of the cruise gap/speed controller: register bank, sequencer, datapath
//
//   port group | direction | flow control | contents
//   in_        | input     | valid/stall  | gap, own, leader and target speed
//   out_       | output    | valid/stall  | acceleration, new speed, law code
//   cfg_       | input     | write enable | gains and headway, 3-bit index
//
// a word is taken in the idle state; six sequencer steps (headway multiply,
// error, law pick, gain multiply, rounding, speed) and a load step follow, so
// no new word is taken until the last one is in the output register.
// a stalled output holds the sequencer in its load step until it frees.
// reset clears the sequencer and the mode bit (speed law) and loads the
// default gains and headway.
`default_nettype none

`include "acc_gap_speed_controller_top_assert.svh"

module acc_gap_speed_controller_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [23:0] in_gap_distance,
  input  wire logic        [15:0] in_own_speed,
  input  wire logic        [15:0] in_leader_speed,
  input  wire logic        [15:0] in_target_speed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [15:0] out_accel_value,
  output logic             [15:0] out_next_speed,
  output logic             [1:0]  out_law_used,
  input  wire logic               cfg_we,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [15:0] cfg_wdata
);

  acc_gsc_pkg::cfg_t cfg_r;
  acc_gsc_pkg::cmd_t cmd;
  acc_gsc_pkg::sts_t sts;
  logic              busy;

  // configuration register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_gain         <= -16'sd6554;
      cfg_r.gap_gain_speed     <= 16'sd1147;
      cfg_r.gap_gain_space     <= 16'sd3768;
      cfg_r.closing_gain_speed <= 16'sd13107;
      cfg_r.closing_gain_space <= 16'sd655;
      cfg_r.avoid_gain_speed   <= 16'sd3768;
      cfg_r.avoid_gain_space   <= 16'sd13107;
      cfg_r.headway_time       <= 12'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        acc_gsc_pkg::CFG_SPEED_GAIN:         cfg_r.speed_gain         <= cfg_wdata;
        acc_gsc_pkg::CFG_GAP_GAIN_SPEED:     cfg_r.gap_gain_speed     <= cfg_wdata;
        acc_gsc_pkg::CFG_GAP_GAIN_SPACE:     cfg_r.gap_gain_space     <= cfg_wdata;
        acc_gsc_pkg::CFG_CLOSING_GAIN_SPEED: cfg_r.closing_gain_speed <= cfg_wdata;
        acc_gsc_pkg::CFG_CLOSING_GAIN_SPACE: cfg_r.closing_gain_space <= cfg_wdata;
        acc_gsc_pkg::CFG_AVOID_GAIN_SPEED:   cfg_r.avoid_gain_speed   <= cfg_wdata;
        acc_gsc_pkg::CFG_AVOID_GAIN_SPACE:   cfg_r.avoid_gain_space   <= cfg_wdata;
        acc_gsc_pkg::CFG_HEADWAY_TIME:       cfg_r.headway_time       <= cfg_wdata[11:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  // sequencer
  acc_gsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  // datapath
  acc_gsc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .sts             (sts),
    .in_gap_distance (in_gap_distance),
    .in_own_speed    (in_own_speed),
    .in_leader_speed (in_leader_speed),
    .in_target_speed (in_target_speed),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_accel_value (out_accel_value),
    .out_next_speed  (out_next_speed),
    .out_law_used    (out_law_used)
  );

  assign in_stall = busy;

  // a taken word keeps the input stalled while it is worked on
  `ACC_GSC_AST_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  // a new output word only comes from a busy sequencer
  `ACC_GSC_AST_IMPL(a_out_from_busy, $rose(out_valid), $past(in_stall))

endmodule

`default_nettype wire
